@@ hw/rtl/pcfc_pkg.sv @@
`default_nettype none
package pcfc_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int DIST_W          = 18;

    localparam logic [7:0] VGA_HI = 8'hA8;
    localparam logic [7:0] VGA_LO = 8'h57;

    typedef enum logic [1:0] {
        DEPTH_PAL8     = 2'd0,
        DEPTH_RGB565   = 2'd1,
        DEPTH_RGB888   = 2'd2,
        DEPTH_ARGB8888 = 2'd3
    } depth_t;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    typedef logic [7:0]  chan_t;
    typedef logic [31:0] pixel_t;
    typedef logic [23:0] rgb_t;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic in_is_scan;
        logic scan_last;
    } dp_stat_t;

    function automatic chan_t vga_level(input logic [7:0] idx, input int hi_bit,
                                        input int lo_bit);
        chan_t v;
        v = 8'd0;
        if (idx[hi_bit])
        begin
            v = v + VGA_HI;
        end
        if (idx[lo_bit])
        begin
            v = v + VGA_LO;
        end
        return v;
    endfunction

    function automatic rgb_t palette_entry(input logic [7:0] idx);
        rgb_t e;
        if (idx < 8'd64)
        begin
            e = {vga_level(idx, 2, 5), vga_level(idx, 1, 4), vga_level(idx, 0, 3)};
        end
        else
        begin
            e = 24'd0;
        end
        return e;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pcfc_if.sv @@
`default_nettype none
interface pcfc_in_if;
    import pcfc_pkg::*;

    logic  valid;
    logic  ready;
    op_t   operation;
    chan_t in_red;
    chan_t in_green;
    chan_t in_blue;
    chan_t in_alpha;
    pixel_t in_pixel;

    modport source (output valid, operation, in_red, in_green, in_blue, in_alpha, in_pixel,
                    input ready);
    modport sink (input valid, operation, in_red, in_green, in_blue, in_alpha, in_pixel,
                  output ready);
endinterface

interface pcfc_out_if;
    import pcfc_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t out_pixel;
    chan_t  out_red;
    chan_t  out_green;
    chan_t  out_blue;
    chan_t  out_alpha;

    modport source (output valid, out_pixel, out_red, out_green, out_blue, out_alpha,
                    input ready);
    modport sink (input valid, out_pixel, out_red, out_green, out_blue, out_alpha,
                  output ready);
endinterface

interface pcfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pcfc_ctrl.sv @@
`default_nettype none
module pcfc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire pcfc_pkg::dp_stat_t stat,
    output pcfc_pkg::dp_cmd_t      cmd
);
    import pcfc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = stat.in_is_scan ? ST_SCAN : ST_LOAD;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/pcfc_dp.sv @@
`default_nettype none
module pcfc_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_data,
    input  wire pcfc_pkg::op_t     in_operation,
    input  wire pcfc_pkg::chan_t   in_red,
    input  wire pcfc_pkg::chan_t   in_green,
    input  wire pcfc_pkg::chan_t   in_blue,
    input  wire pcfc_pkg::chan_t   in_alpha,
    input  wire pcfc_pkg::pixel_t  in_pixel,
    input  wire pcfc_pkg::dp_cmd_t cmd,
    output pcfc_pkg::dp_stat_t     stat,
    output pcfc_pkg::pixel_t       out_pixel,
    output pcfc_pkg::chan_t        out_red,
    output pcfc_pkg::chan_t        out_green,
    output pcfc_pkg::chan_t        out_blue,
    output pcfc_pkg::chan_t        out_alpha
);
    import pcfc_pkg::*;

    depth_t depth_reg;

    op_t    op_reg;
    chan_t  r_reg;
    chan_t  g_reg;
    chan_t  b_reg;
    chan_t  a_reg;
    pixel_t px_reg;

    logic [IDX_W-1:0]  scan_cnt_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [DIST_W-1:0] best_dist_reg;

    pixel_t o_px_reg;
    chan_t  o_r_reg;
    chan_t  o_g_reg;
    chan_t  o_b_reg;
    chan_t  o_a_reg;

    rgb_t              scan_entry;
    chan_t             d_r;
    chan_t             d_g;
    chan_t             d_b;
    logic [15:0]       sq_r;
    logic [15:0]       sq_g;
    logic [15:0]       sq_b;
    logic [DIST_W-1:0] cand_dist;

    rgb_t   dec_entry;
    pixel_t o_px_next;
    chan_t  o_r_next;
    chan_t  o_g_next;
    chan_t  o_b_next;
    chan_t  o_a_next;

    assign stat.in_is_scan = (in_operation == OP_ENCODE) && (depth_reg == DEPTH_PAL8);
    assign stat.scan_last  = (scan_cnt_reg == IDX_W'(PALETTE_ENTRIES - 1));

    always_comb
    begin
        scan_entry = palette_entry(8'(scan_cnt_reg));
        d_r  = (r_reg > scan_entry[23:16]) ? r_reg - scan_entry[23:16]
                                           : scan_entry[23:16] - r_reg;
        d_g  = (g_reg > scan_entry[15:8]) ? g_reg - scan_entry[15:8]
                                          : scan_entry[15:8] - g_reg;
        d_b  = (b_reg > scan_entry[7:0]) ? b_reg - scan_entry[7:0]
                                         : scan_entry[7:0] - b_reg;
        sq_r = d_r * d_r;
        sq_g = d_g * d_g;
        sq_b = d_b * d_b;
        cand_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
    end

    always_comb
    begin
        dec_entry = (px_reg[7:0] < 9'(PALETTE_ENTRIES)) ? palette_entry(px_reg[7:0]) : 24'd0;
        o_px_next = '0;
        o_r_next  = '0;
        o_g_next  = '0;
        o_b_next  = '0;
        o_a_next  = '0;
        if (op_reg == OP_ENCODE)
        begin
            unique case (depth_reg)
                DEPTH_PAL8:     o_px_next = 32'(best_idx_reg);
                DEPTH_RGB565:   o_px_next = {16'd0, r_reg[7:3], g_reg[7:2], b_reg[7:3]};
                DEPTH_RGB888:   o_px_next = {8'd0, r_reg, g_reg, b_reg};
                DEPTH_ARGB8888: o_px_next = {a_reg, r_reg, g_reg, b_reg};
                default:        o_px_next = '0;
            endcase
        end
        else
        begin
            o_a_next = 8'hFF;
            unique case (depth_reg)
                DEPTH_PAL8:
                begin
                    o_r_next = dec_entry[23:16];
                    o_g_next = dec_entry[15:8];
                    o_b_next = dec_entry[7:0];
                end
                DEPTH_RGB565:
                begin
                    o_r_next = {px_reg[15:11], 3'b000};
                    o_g_next = {px_reg[10:5], 2'b00};
                    o_b_next = {px_reg[4:0], 3'b000};
                end
                DEPTH_RGB888:
                begin
                    o_r_next = px_reg[23:16];
                    o_g_next = px_reg[15:8];
                    o_b_next = px_reg[7:0];
                end
                DEPTH_ARGB8888:
                begin
                    o_r_next = px_reg[23:16];
                    o_g_next = px_reg[15:8];
                    o_b_next = px_reg[7:0];
                    o_a_next = px_reg[31:24];
                end
                default:
                begin
                    o_r_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_ARGB8888;
        end
        else if (cfg_we)
        begin
            depth_reg <= depth_t'(cfg_data);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= in_operation;
            r_reg         <= in_red;
            g_reg         <= in_green;
            b_reg         <= in_blue;
            a_reg         <= in_alpha;
            px_reg        <= in_pixel;
            scan_cnt_reg  <= '0;
            best_idx_reg  <= '0;
            best_dist_reg <= '1;
        end
        else if (cmd.scan_step)
        begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
            if (cand_dist < best_dist_reg)
            begin
                best_dist_reg <= cand_dist;
                best_idx_reg  <= scan_cnt_reg;
            end
        end
        if (cmd.load_out)
        begin
            o_px_reg <= o_px_next;
            o_r_reg  <= o_r_next;
            o_g_reg  <= o_g_next;
            o_b_reg  <= o_b_next;
            o_a_reg  <= o_a_next;
        end
    end

    assign out_pixel = o_px_reg;
    assign out_red   = o_r_reg;
    assign out_green = o_g_reg;
    assign out_blue  = o_b_reg;
    assign out_alpha = o_a_reg;

endmodule
`default_nettype wire

@@ hw/rtl/pixel_colour_format_converter.sv @@
// Each result is registered in the output register; the load waits while a previous result is
// still pending. For an 8-bit palette encode, a nearest-colour search over all 256 palette
// entries comes first and takes one palette entry per cycle. A new input is taken only when idle,
// and it is taken while the previous result waits in the output register.
// Reset is asynchronous and active low; it empties the block and sets the depth to 32-bit.
`default_nettype none
module pixel_colour_format_converter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pcfc_cfg_if.sink   cfg,
    pcfc_in_if.sink    in_ch,
    pcfc_out_if.source out_ch
);
    import pcfc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg.ready = 1'b1;

    pcfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pcfc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg.valid),
        .cfg_data     (cfg.data),
        .in_operation (in_ch.operation),
        .in_red       (in_ch.in_red),
        .in_green     (in_ch.in_green),
        .in_blue      (in_ch.in_blue),
        .in_alpha     (in_ch.in_alpha),
        .in_pixel     (in_ch.in_pixel),
        .cmd          (cmd),
        .stat         (stat),
        .out_pixel    (out_ch.out_pixel),
        .out_red      (out_ch.out_red),
        .out_green    (out_ch.out_green),
        .out_blue     (out_ch.out_blue),
        .out_alpha    (out_ch.out_alpha)
    );

    a_no_input_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !in_ch.ready)
        else $error("An input transaction was possible during the palette search.");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_ch.valid || out_ch.ready))
        else $error("A pending result was overwritten.");

    a_scan_follows_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && stat.in_is_scan) |=> cmd.scan_step)
        else $error("A palette encode did not start its search.");

    a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_ch.valid)
        else $error("A loaded result was not presented.");

endmodule
`default_nettype wire
